/* src/pebs_pkg.sv */
// ----------------------------------------------------------------------------
// pebs_pkg
// Shared constants, command, status and state types for the peak search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pebs_pkg;

    localparam int DEPTH       = 1024;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SAMPLE_W    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One request from the front end to the search engine
    typedef struct packed {
        logic                       do_write;
        logic                       do_search;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
        logic [ADDR_W-1:0]          upper;
        logic                       ovf;
    } pebs_cmd_t;

    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } pebs_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } pebs_state_t;

endpackage

`default_nettype wire

/* src/peak_element_binary_search_top.sv */
// ----------------------------------------------------------------------------
// peak_element_binary_search_top
// Loads a signed sample sequence and finds the index of a local peak.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each request carries one sample; last_sample
// marks the end of a sequence. Samples enter a 4-entry request queue and are
// written to a 1024-entry store at one per cycle while the engine is idle, so
// loading runs at one sample per cycle between searches. Samples beyond the
// store depth are dropped and flagged. After the last sample the search
// engine runs a binary search over the stored samples, each halving step a
// store read followed by a compare. While the search runs the engine takes
// no new requests; the queue absorbs up to four samples, then full rises.
// Result channel: empty/pop. One result per sequence (peak_index,
// overflowed) waits in an output register; a stalled receiver blocks the
// next search from finishing, and the queue then fills behind it.
// Reset clears the fill count, queue pointers, engine state and output valid
// flag; the store holds no reset value and needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_element_binary_search_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [pebs_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic                                 last_sample,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic [pebs_pkg::ADDR_W-1:0]               peak_index,
    output logic                                      overflowed
);

    logic                 q_full;
    logic                 q_wr;
    logic                 q_rd;
    logic                 q_empty;
    pebs_pkg::pebs_cmd_t  q_wr_cmd;
    pebs_pkg::pebs_cmd_t  q_rd_cmd;
    pebs_pkg::pebs_stat_t stat;

    pebs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_value (sample_value),
        .last_sample  (last_sample),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_cmd        (q_wr_cmd)
    );

    pebs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_cmd (q_wr_cmd),
        .full   (q_full),
        .rd_en  (q_rd),
        .rd_cmd (q_rd_cmd),
        .empty  (q_empty)
    );

    pebs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .q_cmd      (q_rd_cmd),
        .pop        (pop),
        .empty      (empty),
        .peak_index (peak_index),
        .overflowed (overflowed),
        .stat       (stat)
    );

    a_no_write_when_full: assert property (
        @(posedge clk) disable iff (!rst_n) !(q_wr && q_full))
        else $error("request written into a full queue");

    a_no_read_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n) stat.busy |-> !q_rd)
        else $error("request taken while a search runs");

    a_bounds_ordered: assert property (
        @(posedge clk) disable iff (!rst_n) stat.busy |-> (stat.lo <= stat.hi))
        else $error("search bounds crossed");

endmodule

`default_nettype wire

/* src/pebs_front.sv */
// ----------------------------------------------------------------------------
// pebs_front
// Accepts samples, tracks fill count and overflow, and issues write and
// search requests to the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pebs_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [pebs_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic                                last_sample,
    input  wire logic                                q_full,
    output logic                                     q_wr,
    output pebs_pkg::pebs_cmd_t                      q_cmd
);

    logic [pebs_pkg::CNT_W-1:0] count_reg;
    logic [pebs_pkg::CNT_W-1:0] count_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       accept;
    logic                       stored;

    always_comb
    begin
        accept = push && !q_full;
        stored = (count_reg < pebs_pkg::CNT_W'(pebs_pkg::DEPTH));

        q_cmd.do_write  = stored;
        q_cmd.do_search = last_sample;
        q_cmd.addr      = count_reg[pebs_pkg::ADDR_W-1:0];
        q_cmd.data      = sample_value;
        // last stored index: this sample if kept, else the final entry
        q_cmd.upper     = stored ? count_reg[pebs_pkg::ADDR_W-1:0]
                                 : pebs_pkg::ADDR_W'(pebs_pkg::DEPTH - 1);
        q_cmd.ovf       = ovf_reg || !stored;

        q_wr = accept && (stored || last_sample);

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last_sample)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (stored)
            begin
                count_next = count_reg + pebs_pkg::CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    assign full = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

/* src/pebs_queue.sv */
// ----------------------------------------------------------------------------
// pebs_queue
// Short request queue between the front end and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pebs_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire pebs_pkg::pebs_cmd_t wr_cmd,
    output logic                     full,
    input  wire logic                rd_en,
    output pebs_pkg::pebs_cmd_t      rd_cmd,
    output logic                     empty
);

    pebs_pkg::pebs_cmd_t          entries_reg [pebs_pkg::QUEUE_DEPTH];
    logic [pebs_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [pebs_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [pebs_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [pebs_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [pebs_pkg::QCNT_W-1:0]  cnt_reg;
    logic [pebs_pkg::QCNT_W-1:0]  cnt_next;
    logic                         do_wr;
    logic                         do_rd;

    always_comb
    begin
        full  = (cnt_reg == pebs_pkg::QCNT_W'(pebs_pkg::QUEUE_DEPTH));
        empty = (cnt_reg == '0);
        do_wr = wr_en && !full;
        do_rd = rd_en && !empty;

        wr_ptr_next = wr_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == pebs_pkg::QPTR_W'(pebs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + pebs_pkg::QPTR_W'(1);
        end

        rd_ptr_next = rd_ptr_reg;
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == pebs_pkg::QPTR_W'(pebs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + pebs_pkg::QPTR_W'(1);
        end

        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + pebs_pkg::QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - pebs_pkg::QCNT_W'(1);
        end

        rd_cmd = entries_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

/* src/pebs_back.sv */
// ----------------------------------------------------------------------------
// pebs_back
// Sample store and binary search engine with a one-entry result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pebs_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    output logic                             q_rd,
    input  wire pebs_pkg::pebs_cmd_t         q_cmd,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [pebs_pkg::ADDR_W-1:0]      peak_index,
    output logic                             overflowed,
    output pebs_pkg::pebs_stat_t             stat
);

    logic signed [pebs_pkg::SAMPLE_W-1:0] mem [pebs_pkg::DEPTH];
    logic signed [pebs_pkg::SAMPLE_W-1:0] rd_a_reg;
    logic signed [pebs_pkg::SAMPLE_W-1:0] rd_b_reg;

    pebs_pkg::pebs_state_t         state_reg;
    pebs_pkg::pebs_state_t         state_next;
    logic [pebs_pkg::ADDR_W-1:0]   lo_reg;
    logic [pebs_pkg::ADDR_W-1:0]   lo_next;
    logic [pebs_pkg::ADDR_W-1:0]   hi_reg;
    logic [pebs_pkg::ADDR_W-1:0]   hi_next;
    logic                          ovf_reg;
    logic                          ovf_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [pebs_pkg::ADDR_W-1:0]   peak_reg;
    logic [pebs_pkg::ADDR_W-1:0]   peak_next;
    logic                          out_ovf_reg;
    logic                          out_ovf_next;

    logic [pebs_pkg::ADDR_W:0]     sum;
    logic [pebs_pkg::ADDR_W-1:0]   mid;
    logic [pebs_pkg::ADDR_W-1:0]   mid_p1;
    logic                          go_right;
    logic                          out_free;
    logic                          mem_we;

    always_comb
    begin
        sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid      = sum[pebs_pkg::ADDR_W:1];
        mid_p1   = mid + pebs_pkg::ADDR_W'(1);
        go_right = (rd_a_reg < rd_b_reg);
        out_free = !out_valid_reg || pop;

        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !pop;
        peak_next      = peak_reg;
        out_ovf_next   = out_ovf_reg;
        q_rd           = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            pebs_pkg::ST_IDLE:
            begin
                q_rd = !q_empty;
                if (!q_empty)
                begin
                    mem_we = q_cmd.do_write;
                    if (q_cmd.do_search)
                    begin
                        lo_next    = '0;
                        hi_next    = q_cmd.upper;
                        ovf_next   = q_cmd.ovf;
                        state_next = (q_cmd.upper == '0) ? pebs_pkg::ST_DONE
                                                         : pebs_pkg::ST_READ;
                    end
                end
            end
            pebs_pkg::ST_READ:
            begin
                state_next = pebs_pkg::ST_CMP;
            end
            pebs_pkg::ST_CMP:
            begin
                // climb toward the larger neighbor
                if (go_right)
                begin
                    lo_next = mid_p1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = (lo_next == hi_next) ? pebs_pkg::ST_DONE
                                                  : pebs_pkg::ST_READ;
            end
            pebs_pkg::ST_DONE:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    peak_next      = lo_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = pebs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pebs_pkg::ST_IDLE;
            end
        endcase

        empty      = !out_valid_reg;
        peak_index = peak_reg;
        overflowed = out_ovf_reg;

        stat.busy = (state_reg != pebs_pkg::ST_IDLE);
        stat.lo   = lo_reg;
        stat.hi   = hi_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pebs_pkg::ST_IDLE;
            lo_reg        <= '0;
            hi_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        peak_reg    <= peak_next;
        out_ovf_reg <= out_ovf_next;
    end

    // Sample store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_cmd.addr] <= q_cmd.data;
        end
        rd_a_reg <= mem[mid];
        rd_b_reg <= mem[mid_p1];
    end

endmodule

`default_nettype wire

/* tb/peak_search_checker.sv */
// ----------------------------------------------------------------------------
// peak_search_checker
// Watches the sample and result channels of the peak search block, predicts
// the peak index and overflow flag of every closed sequence and compares
// each popped result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peak_search_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    input  wire logic                                 full,
    input  wire logic signed [pebs_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic                                 last_sample,
    input  wire logic                                 empty,
    input  wire logic                                 pop,
    input  wire logic [pebs_pkg::ADDR_W-1:0]          peak_index,
    input  wire logic                                 overflowed,
    output int                                        mismatch_count,
    output int                                        results_pending
);

    typedef struct packed {
        logic [pebs_pkg::ADDR_W-1:0] peak;
        logic                        ovf;
    } peak_result_t;

    logic signed [pebs_pkg::SAMPLE_W-1:0] sample_mem [pebs_pkg::DEPTH];
    int                                   fill_count;
    logic                                 dropped;
    peak_result_t                         peak_expect_q [$];
    peak_result_t                         want;

    initial
    begin
        mismatch_count  = 0;
        results_pending = 0;
        fill_count      = 0;
        dropped         = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Store one sample; on the closing sample run the search and queue the result.
    task automatic load_sample(input logic signed [pebs_pkg::SAMPLE_W-1:0] value,
                               input logic is_last);
        int lo;
        int hi;
        int mid;
        peak_result_t res;
        if (fill_count < pebs_pkg::DEPTH)
        begin
            sample_mem[fill_count] = value;
            fill_count++;
        end
        else
            dropped = 1'b1;
        if (is_last)
        begin
            lo = 0;
            hi = fill_count - 1;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                // only a strict rise moves the lower bound
                if (sample_mem[mid] < sample_mem[mid + 1])
                    lo = mid + 1;
                else
                    hi = mid;
            end
            res.peak = lo[pebs_pkg::ADDR_W-1:0];
            res.ovf  = dropped;
            peak_expect_q.push_back(res);
            results_pending = peak_expect_q.size();
            fill_count = 0;
            dropped    = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count = 0;
            dropped    = 1'b0;
            peak_expect_q.delete();
            results_pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (peak_expect_q.size() == 0)
                    flag_error($sformatf("result with none pending: peak_index=%0d overflowed=%0b",
                                         peak_index, overflowed));
                else
                begin
                    want = peak_expect_q.pop_front();
                    results_pending = peak_expect_q.size();
                    if (peak_index !== want.peak)
                        flag_error($sformatf("peak_index %0d, expected %0d",
                                             peak_index, want.peak));
                    if (overflowed !== want.ovf)
                        flag_error($sformatf("overflowed %0b, expected %0b",
                                             overflowed, want.ovf));
                end
            end
            if (push && !full)
                load_sample(sample_value, last_sample);
        end
    end

endmodule

/* tb/tb_peak_element_binary_search_top.sv */
// ----------------------------------------------------------------------------
// tb_peak_element_binary_search_top
// Drives sample sequences into the peak search block under random push and
// pop gaps (none in the last random phase): short directed sequences, then
// random sequences of mixed shape; a checker module scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_peak_element_binary_search_top;

    localparam int RANDOM_SAMPLES  = 580;
    localparam int MIN_RANDOM_SEQS = 20;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 64;

    localparam logic signed [pebs_pkg::SAMPLE_W-1:0] MAX_SAMPLE =
        {1'b0, {(pebs_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [pebs_pkg::SAMPLE_W-1:0] MIN_SAMPLE =
        {1'b1, {(pebs_pkg::SAMPLE_W-1){1'b0}}};

    typedef enum int {
        RUN_RISE,
        RUN_FALL,
        RUN_WIDE,
        RUN_NARROW,
        RUN_FLAT
    } run_kind_t;

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 push         = 1'b0;
    logic                                 full;
    logic signed [pebs_pkg::SAMPLE_W-1:0] sample_value = '0;
    logic                                 last_sample  = 1'b0;
    logic                                 empty;
    logic                                 pop          = 1'b0;
    logic [pebs_pkg::ADDR_W-1:0]          peak_index;
    logic                                 overflowed;

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int samples_sent  = 0;
    int seqs_sent     = 0;
    int quiet_cycles  = 0;
    int mismatch_count;
    int results_pending;

    peak_element_binary_search_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_value (sample_value),
        .last_sample  (last_sample),
        .empty        (empty),
        .pop          (pop),
        .peak_index   (peak_index),
        .overflowed   (overflowed)
    );

    peak_search_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .sample_value    (sample_value),
        .last_sample     (last_sample),
        .empty           (empty),
        .pop             (pop),
        .peak_index      (peak_index),
        .overflowed      (overflowed),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: pop at random according to the current phase.
    always @(posedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
            $display("** peak_element_binary_search_top: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [pebs_pkg::SAMPLE_W-1:0] sample_for(
        input run_kind_t kind, input int pos);
        case (kind)
            RUN_RISE:   return pos * 5 - 2000;
            RUN_FALL:   return 1000 - pos * 7;
            RUN_NARROW: return $urandom_range(3) - 1;
            RUN_FLAT:   return 17;
            default:
            begin
                if ($urandom_range(7) == 0)
                    return $urandom_range(1) ? MAX_SAMPLE : MIN_SAMPLE;
                return $urandom;
            end
        endcase
    endfunction

    // Hold the request until full is seen low ahead of an edge.
    task automatic send_sample(input logic signed [pebs_pkg::SAMPLE_W-1:0] value,
                               input logic is_last);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        sample_value <= value;
        last_sample  <= is_last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        samples_sent++;
    endtask

    task automatic send_run(input int len, input run_kind_t kind);
        for (int i = 0; i < len; i++)
            send_sample(sample_for(kind, i), i == len - 1);
        seqs_sent++;
    endtask

    initial
    begin
        run_kind_t kind;
        int        len;
        send_idle_pct = 23;
        take_idle_pct = 77;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single sample, rising pair, falling and rising pairs at the extremes
        send_sample(5, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(7, 1'b1);
        send_sample(MAX_SAMPLE, 1'b0);
        send_sample(MIN_SAMPLE, 1'b1);
        send_sample(MIN_SAMPLE, 1'b0);
        send_sample(MAX_SAMPLE, 1'b1);
        // equal neighbors must not move the lower bound; then an inner peak and a valley
        send_run(3, RUN_FLAT);
        send_sample(1, 1'b0);
        send_sample(3, 1'b0);
        send_sample(9, 1'b0);
        send_sample(4, 1'b0);
        send_sample(2, 1'b1);
        send_sample(5, 1'b0);
        send_sample(1, 1'b0);
        send_sample(5, 1'b1);

        samples_sent = 0;
        seqs_sent    = 0;
        while (samples_sent < RANDOM_SAMPLES || seqs_sent < MIN_RANDOM_SEQS)
        begin
            if (samples_sent < RANDOM_SAMPLES / 3)
            begin
                send_idle_pct = 23;
                take_idle_pct = 77;
            end
            else if (samples_sent < 2 * RANDOM_SAMPLES / 3)
            begin
                send_idle_pct = 77;
                take_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            kind = run_kind_t'($urandom_range(RUN_FLAT));
            len  = $urandom_range(24, 1);
            send_run(len, kind);
        end
        push <= 1'b0;
        send_idle_pct = 0;
        take_idle_pct = 0;

        while (results_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("** peak_element_binary_search_top: PASSED **");
        else
            $display("** peak_element_binary_search_top: FAILED **");
        $finish;
    end

endmodule

/* peak_element_binary_search_top.f */
src/pebs_pkg.sv
src/pebs_front.sv
src/pebs_queue.sv
src/pebs_back.sv
src/peak_element_binary_search_top.sv
tb/peak_search_checker.sv
tb/tb_peak_element_binary_search_top.sv
